// File: src/b64sd_pkg.sv
// ---------------------------------------------------------------------------
// b64sd_pkg: shared types and constants for the strict base64 decoder
// Holds the result item layout, the queue write request, the status codes,
// the character constants and the alphabet lookup.
// ---------------------------------------------------------------------------
package b64sd_pkg;

  // Status codes carried on the closing status item
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR = 2'd2;
  localparam logic [1:0] ST_NONCANON = 2'd3;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Character constants
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  // Sextet offsets
  localparam logic [7:0] OFS_LOWER = 8'd26;
  localparam logic [7:0] OFS_DIGIT = 8'd52;
  localparam logic [5:0] SX_PLUS   = 6'd62;
  localparam logic [5:0] SX_SLASH  = 6'd63;

  // Result queue depth
  localparam int unsigned RQ_DEPTH_DEF = 4;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       end_of_run;
  } result_t;

  // Write request from the step unit into the result queue
  typedef struct packed {
    logic [1:0] count;   // number of entries written: 0, 1 or 2
    result_t    first;
    result_t    second;
  } rq_push_t;

  // Decode one character: bit 6 set means not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] diff;
    logic [6:0] res;
    diff = 8'd0;
    res  = 7'h40;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      diff = ch - CH_UPPER_A;
      res  = {1'b0, diff[5:0]};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      diff = ch - CH_LOWER_A + OFS_LOWER;
      res  = {1'b0, diff[5:0]};
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      diff = ch - CH_DIGIT_0 + OFS_DIGIT;
      res  = {1'b0, diff[5:0]};
    end else if (ch == CH_PLUS) begin
      res = {1'b0, SX_PLUS};
    end else if (ch == CH_SLASH) begin
      res = {1'b0, SX_SLASH};
    end
    return res;
  endfunction

  // Keep the first error of a run
  function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

// File: src/b64sd_step.sv
// ---------------------------------------------------------------------------
// b64sd_step: per-character decode and run state
// Decodes the registered character, checks the strict rules, updates the
// group state and builds up to two result items for the result queue.
// ---------------------------------------------------------------------------
module b64sd_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          character,
  input  logic                last,
  output b64sd_pkg::rq_push_t push
);
  import b64sd_pkg::*;

  logic [1:0] grp_pos_r, grp_pos_nxt;
  logic [5:0] prev_sx_r, prev_sx_nxt;
  logic       third_pad_r, third_pad_nxt;
  logic       closed_r, closed_nxt;
  logic [1:0] err_r, err_nxt;

  logic [6:0] sx;
  logic       sx_ok;
  logic       is_pad;
  logic       have_byte;
  logic [7:0] byte_val;
  result_t    data_item;
  result_t    status_item;

  assign sx     = sextet_of(character);
  assign sx_ok  = !sx[6];
  assign is_pad = (character == CH_PAD);

  // Apply the strict rules for the character at the current group position
  always_comb begin
    grp_pos_nxt   = grp_pos_r;
    prev_sx_nxt   = prev_sx_r;
    third_pad_nxt = third_pad_r;
    closed_nxt    = closed_r;
    err_nxt       = err_r;
    have_byte     = 1'b0;
    byte_val      = 8'd0;
    if (fire) begin
      if (closed_r) begin
        err_nxt = first_err(err_nxt, ST_BAD_CHAR);
      end
      unique case (grp_pos_r)
        2'd0: begin
          if (!sx_ok) err_nxt = first_err(err_nxt, ST_BAD_CHAR);
          else prev_sx_nxt = sx[5:0];
        end
        2'd1: begin
          if (!sx_ok) begin
            err_nxt = first_err(err_nxt, ST_BAD_CHAR);
          end else begin
            byte_val    = {prev_sx_r, sx[5:4]};
            have_byte   = 1'b1;
            prev_sx_nxt = sx[5:0];
          end
        end
        2'd2: begin
          if (is_pad) begin
            third_pad_nxt = 1'b1;
          end else if (!sx_ok) begin
            err_nxt = first_err(err_nxt, ST_BAD_CHAR);
          end else begin
            byte_val    = {prev_sx_r[3:0], sx[5:2]};
            have_byte   = 1'b1;
            prev_sx_nxt = sx[5:0];
          end
        end
        default: begin
          if (third_pad_r) begin
            if (!is_pad) begin
              err_nxt = first_err(err_nxt, ST_BAD_CHAR);
            end else begin
              closed_nxt = 1'b1;
              if (!last) err_nxt = first_err(err_nxt, ST_BAD_CHAR);
              else if (prev_sx_r[3:0] != 4'd0) err_nxt = first_err(err_nxt, ST_NONCANON);
            end
          end else if (is_pad) begin
            closed_nxt = 1'b1;
            if (!last) err_nxt = first_err(err_nxt, ST_BAD_CHAR);
            else if (prev_sx_r[1:0] != 2'd0) err_nxt = first_err(err_nxt, ST_NONCANON);
          end else if (!sx_ok) begin
            err_nxt = first_err(err_nxt, ST_BAD_CHAR);
          end else begin
            byte_val    = {prev_sx_r[1:0], sx[5:0]};
            have_byte   = 1'b1;
            prev_sx_nxt = sx[5:0];
          end
          third_pad_nxt = 1'b0;
        end
      endcase
      grp_pos_nxt = grp_pos_r + 2'd1;
      // Length error overrides everything else
      if (last && grp_pos_r != 2'd3) err_nxt = ST_LENGTH;
    end
  end

  // Build the result items
  always_comb begin
    data_item   = '{kind: KIND_DATA, data_byte: byte_val, status: ST_OK, end_of_run: 1'b0};
    status_item = '{kind: KIND_STATUS, data_byte: 8'd0, status: err_nxt, end_of_run: 1'b1};
    push        = '0;
    if (fire) begin
      if (have_byte && err_nxt == ST_OK) begin
        push.first = data_item;
        if (last) begin
          push.second = status_item;
          push.count  = 2'd2;
        end else begin
          push.count = 2'd1;
        end
      end else if (last) begin
        push.first = status_item;
        push.count = 2'd1;
      end
    end
  end

  // Hold run state; clear it after the final character
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      grp_pos_r   <= 2'd0;
      prev_sx_r   <= 6'd0;
      third_pad_r <= 1'b0;
      closed_r    <= 1'b0;
      err_r       <= ST_OK;
    end else begin
      grp_pos_r   <= grp_pos_nxt;
      prev_sx_r   <= prev_sx_nxt;
      third_pad_r <= third_pad_nxt;
      closed_r    <= closed_nxt;
      err_r       <= err_nxt;
    end
  end

  // A final character always leaves a fresh run behind
  a_run_reset: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> grp_pos_r == 2'd0 && err_r == ST_OK && !closed_r)
    else $error("run state not cleared after final character");

  // Once an error is recorded, no data byte leaves
  a_no_data_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_OK |-> push.count == 2'd0 || push.first.kind == KIND_STATUS)
    else $error("data byte emitted after an error");

endmodule

// File: src/b64sd_rfifo.sv
// ---------------------------------------------------------------------------
// b64sd_rfifo: result queue
// Small queue that takes up to two result items per cycle and delivers one
// per cycle on the output channel while out_ready is high.
// ---------------------------------------------------------------------------
module b64sd_rfifo #(
  parameter int unsigned DEPTH = b64sd_pkg::RQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  b64sd_pkg::rq_push_t push,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output b64sd_pkg::result_t  out_item
);
  import b64sd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_ptr_p1;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  // Room for a full two-item request
  assign has_room  = (count_r <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    unique case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    if (pop) rd_ptr_nxt = ptr_inc(rd_ptr_r);
    count_nxt = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entries of a write request
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) mem_r[wr_ptr_p1] <= push.second;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue occupancy out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> count_r <= CW'(DEPTH - 2))
    else $error("result queue written without room");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> push.first.kind == KIND_DATA && push.second.end_of_run)
    else $error("two-item request not a data byte followed by status");

endmodule

// File: src/base64_strict_decoder_core.sv
// ---------------------------------------------------------------------------
// base64_strict_decoder_core: streaming strict base64 decoder
//
//  channel  direction  payload                                  handshake
//  in_      input      character[7:0], last                     valid/ready
//  out_     output     kind, data_byte[7:0], status[1:0],       valid/ready
//                      end_of_run
//
// One character is accepted per cycle while the result queue has room. The
// character is held and decoded in the input register, and its results land
// in the queue, which has RQ_DEPTH entries (four by default). The final
// character yields a status item, after a data byte if it completes one
// without an error. The input register advances only while the queue has
// room for two items, so a stalled output backs up to in_ready. Reset clears
// the run state and empties the queue.
// ---------------------------------------------------------------------------
module base64_strict_decoder_core #(
  parameter int unsigned RQ_DEPTH = b64sd_pkg::RQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic       out_end_of_run
);
  import b64sd_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       fire;
  logic       has_room;
  rq_push_t   push;
  result_t    out_item;

  // Decode the held character once the queue can take its results
  assign fire     = in_valid_r && has_room;
  assign in_ready = !in_valid_r || fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_character;
      last_r <= in_last;
    end
  end

  b64sd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .character (char_r),
    .last      (last_r),
    .push      (push)
  );

  b64sd_rfifo #(
    .DEPTH (RQ_DEPTH)
  ) u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_kind       = out_item.kind;
  assign out_data_byte  = out_item.data_byte;
  assign out_status     = out_item.status;
  assign out_end_of_run = out_item.end_of_run;

endmodule
